/* design/asc_pkg.sv */
`default_nettype none

package asc_pkg;

  // request codes on the input word
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_CAPTURE = 2'd1;
  localparam logic [1:0] REQ_RENDER  = 2'd2;

  localparam int RAW_W     = 24;
  localparam int SAMPLE_W  = 26;
  localparam int WORD_W    = 24;
  localparam int ROW_W     = 9;
  localparam int OUT_COL_W = 8;

  // full-scale converter code used by the column mapping
  localparam int FULL_SCALE  = 8388607;
  // reciprocal shift for the constant divider; covers a 2^25 magnitude
  localparam int RECIP_SHIFT = 25;

  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 8;
  localparam int RES_CNT_W   = $clog2(RES_Q_DEPTH) + 1;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_CAPTURE,
    KIND_RENDER,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SAMPLE_W-1:0]   scaled;
    logic [ROW_W-1:0]      row;
    logic                  row_ok;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]     word;
    logic [OUT_COL_W-1:0]  x_pos;
    logic [OUT_COL_W-1:0]  span_lo;
    logic [OUT_COL_W-1:0]  span_hi;
    logic                  row_ok;
  } res_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage

`default_nettype wire

/* design/asc_ram.sv */
`default_nettype none

module asc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/asc_fifo.sv */
`default_nettype none

module asc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      logic [WIDTH-1:0] pop_data,
  output      logic [PW:0]      count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != (PW+1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/asc_front.sv */
`default_nettype none

module asc_front #(
  parameter int SCREEN_ROWS = 320
) (
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [1:0]                  req_type,
  input  wire logic [asc_pkg::RAW_W-1:0]   sample_raw,
  input  wire logic [asc_pkg::ROW_W-1:0]   row_index,
  input  wire asc_pkg::stat_t              stat,
  output      logic                        q_valid,
  input  wire logic                        q_ready,
  output      asc_pkg::cmd_t               q_cmd
);

  localparam int EXT_W = asc_pkg::ROW_W + 2;

  logic [EXT_W-1:0] row_e;
  logic             row_in, next_in;

  // no words taken while the column store is being initialized
  assign in_ready = q_ready && !stat.clearing;
  assign q_valid  = in_valid && !stat.clearing;

  assign row_e   = EXT_W'(row_index);
  assign row_in  = row_e < EXT_W'(SCREEN_ROWS);
  assign next_in = (row_e + EXT_W'(1)) < EXT_W'(SCREEN_ROWS);

  always_comb begin
    q_cmd.scaled = {sample_raw, 2'b00};
    q_cmd.row    = row_index;
    unique case (req_type)
      asc_pkg::REQ_SAMPLE: begin
        q_cmd.kind   = asc_pkg::KIND_SAMPLE;
        q_cmd.row_ok = 1'b1;
      end
      asc_pkg::REQ_CAPTURE: begin
        q_cmd.kind   = asc_pkg::KIND_CAPTURE;
        q_cmd.row_ok = row_in;
      end
      asc_pkg::REQ_RENDER: begin
        q_cmd.kind   = asc_pkg::KIND_RENDER;
        q_cmd.row_ok = next_in;
      end
      default: begin
        q_cmd.kind   = asc_pkg::KIND_NONE;
        q_cmd.row_ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/asc_back.sv */
`default_nettype none

module asc_back #(
  parameter int RING_DEPTH   = 1024,
  parameter int STEP_SIZE    = 2,
  parameter int SCREEN_WIDTH = 240,
  parameter int SCREEN_ROWS  = 320
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cmd_valid,
  output      logic                            cmd_ready,
  input  wire asc_pkg::cmd_t                   cmd,
  input  wire logic [asc_pkg::RES_CNT_W-1:0]   res_count,
  output      logic                            res_valid,
  output      asc_pkg::res_t                   res,
  output      asc_pkg::stat_t                  stat
);

  localparam int SW      = asc_pkg::SAMPLE_W;
  localparam int AW      = $clog2(RING_DEPTH);
  localparam int RW      = $clog2(SCREEN_ROWS);
  localparam int CW      = $clog2(SCREEN_WIDTH);
  localparam int HALF    = SCREEN_WIDTH / 2;
  localparam int DIVISOR = asc_pkg::FULL_SCALE / HALF;
  localparam int MULT    = (2 ** asc_pkg::RECIP_SHIFT) / DIVISOR;
  localparam int MW      = $clog2(MULT + 1);
  localparam int QW      = $clog2(MULT + 2);
  localparam int PW      = SW + MW;
  localparam int PRW     = SW + 2;
  localparam int EW      = QW + CW + 1;
  localparam int CRW     = asc_pkg::RES_CNT_W + 3;
  localparam int OCW     = asc_pkg::OUT_COL_W;

  localparam logic [31:0] STEP32      = 32'(STEP_SIZE);
  localparam logic [31:0] DEPTH32     = 32'(RING_DEPTH);
  localparam logic [31:0] DSTEP32     = 32'(RING_DEPTH + STEP_SIZE);
  localparam logic [31:0] HALF_RING32 = 32'(RING_DEPTH / 2);

  // ---- issue stage: counters and ring access ----
  logic [31:0]   diff_r, diff_nxt;       // write count minus read count
  logic [AW-1:0] wc_r, wc_nxt;
  logic [AW-1:0] rc_r, rc_nxt;
  logic          full_r, full_nxt;       // ring written all the way round once

  logic          clr_r, clr_nxt;
  logic [RW-1:0] clr_idx_r, clr_idx_nxt;

  logic          issue, credit_ok;
  logic [2:0]    inflight;
  logic          step_ok, ovr;
  logic [AW-1:0] rc_step, rc_cap, rd_addr;
  logic [31:0]   diff_cap;
  logic          is_sample, is_capture;

  logic          s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  asc_pkg::cmd_t s1_cmd_r, s2_cmd_r, s3_cmd_r, s4_cmd_r;
  logic          s1_hit_r;

  assign inflight  = {2'b00, s1_vld_r} + {2'b00, s2_vld_r}
                   + {2'b00, s3_vld_r} + {2'b00, s4_vld_r};
  assign credit_ok = (CRW'(res_count) + CRW'(inflight)) < CRW'(asc_pkg::RES_Q_DEPTH);
  assign cmd_ready = credit_ok && !clr_r;
  assign issue     = cmd_valid && cmd_ready;
  assign is_sample  = (cmd.kind == asc_pkg::KIND_SAMPLE);
  assign is_capture = (cmd.kind == asc_pkg::KIND_CAPTURE);

  assign step_ok  = diff_r >= STEP32;
  assign ovr      = step_ok ? (diff_r > DSTEP32) : (diff_r > DEPTH32);
  assign rc_step  = step_ok ? rc_r + AW'(STEP_SIZE) : rc_r;
  assign rc_cap   = ovr ? wc_r - AW'(RING_DEPTH / 2) : rc_step;
  assign diff_cap = ovr ? HALF_RING32 : (step_ok ? diff_r - STEP32 : diff_r);
  assign rd_addr  = rc_cap - AW'(1);

  always_comb begin
    diff_nxt = diff_r;
    wc_nxt   = wc_r;
    rc_nxt   = rc_r;
    full_nxt = full_r;
    if (issue && is_sample) begin
      diff_nxt = diff_r + 32'd1;
      wc_nxt   = wc_r + AW'(1);
      full_nxt = full_r || (wc_r == AW'(RING_DEPTH - 1));
    end else if (issue && is_capture) begin
      diff_nxt = diff_cap;
      rc_nxt   = rc_cap;
    end
  end

  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + RW'(1);
      if (clr_idx_r == RW'(SCREEN_ROWS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r    <= '0;
      wc_r      <= '0;
      rc_r      <= '0;
      full_r    <= 1'b0;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
    end else begin
      diff_r    <= diff_nxt;
      wc_r      <= wc_nxt;
      rc_r      <= rc_nxt;
      full_r    <= full_nxt;
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
    end
  end

  logic [SW-1:0] ring_rd;

  asc_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (issue && is_sample),
    .waddr (wc_r),
    .wdata (cmd.scaled),
    .re    (issue && is_capture),
    .raddr (rd_addr),
    .rdata (ring_rd)
  );

  // ---- stage 1: sign/magnitude and reciprocal multiply ----
  logic [SW-1:0] s1_val, s1_mag;
  logic          s1_neg;
  logic [PW-1:0] s1_prod;

  assign s1_val  = s1_hit_r ? ring_rd : '0;   // never-written entries read as zero
  assign s1_neg  = s1_val[SW-1];
  assign s1_mag  = s1_neg ? (~s1_val + SW'(1)) : s1_val;
  assign s1_prod = s1_mag * MW'(MULT);

  logic [SW-1:0] s2_mag_r;
  logic          s2_neg_r;
  logic [QW-1:0] s2_qe_r;

  // ---- stage 2: one-step quotient correction ----
  logic [PRW-1:0] s2_back, s2_rem;
  logic [QW-1:0]  s2_q;

  assign s2_back = PRW'(s2_qe_r) * PRW'(DIVISOR);
  assign s2_rem  = PRW'(s2_mag_r) - s2_back;
  assign s2_q    = s2_qe_r + QW'(s2_rem >= PRW'(DIVISOR));

  logic          s3_neg_r;
  logic [QW-1:0] s3_q_r;

  // ---- stage 3: column clamp, column store access ----
  logic [EW-1:0] s3_half, s3_qe, s3_sum;
  logic [CW-1:0] s3_x;
  logic          col_we, col_re;
  logic [RW-1:0] col_waddr, col_addr_a, col_addr_b;
  logic [CW-1:0] col_wdata, col_a, col_b;

  assign s3_half = EW'(HALF);
  assign s3_qe   = EW'(s3_q_r);
  assign s3_sum  = s3_half + s3_qe;

  always_comb begin
    if (s3_neg_r) begin
      s3_x = (s3_qe > s3_half) ? '0 : CW'(s3_half - s3_qe);
    end else begin
      s3_x = (s3_sum >= EW'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH - 1) : CW'(s3_sum);
    end
  end

  assign col_we     = clr_r || (s3_vld_r && s3_cmd_r.kind == asc_pkg::KIND_CAPTURE
                                && s3_cmd_r.row_ok);
  assign col_waddr  = clr_r ? clr_idx_r : RW'(s3_cmd_r.row);
  assign col_wdata  = clr_r ? CW'(HALF) : s3_x;
  assign col_re     = s3_vld_r && s3_cmd_r.kind == asc_pkg::KIND_RENDER && s3_cmd_r.row_ok;
  assign col_addr_a = RW'(s3_cmd_r.row);
  assign col_addr_b = RW'({1'b0, s3_cmd_r.row} + 10'd1);

  // two copies so a render reads its row and the next one together
  asc_ram #(
    .WIDTH (CW),
    .DEPTH (SCREEN_ROWS)
  ) u_col_a (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (col_addr_a),
    .rdata (col_a)
  );

  asc_ram #(
    .WIDTH (CW),
    .DEPTH (SCREEN_ROWS)
  ) u_col_b (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .re    (col_re),
    .raddr (col_addr_b),
    .rdata (col_b)
  );

  logic [CW-1:0] s4_x_r;

  always_ff @(posedge clk) begin
    s1_cmd_r <= cmd;
    s1_hit_r <= full_r || (rd_addr < wc_r);
    s2_cmd_r <= s1_cmd_r;
    s2_mag_r <= s1_mag;
    s2_neg_r <= s1_neg;
    s2_qe_r  <= QW'(s1_prod >> asc_pkg::RECIP_SHIFT);
    s3_cmd_r <= s2_cmd_r;
    s3_neg_r <= s2_neg_r;
    s3_q_r   <= s2_q;
    s4_cmd_r <= s3_cmd_r;
    s4_x_r   <= s3_x;
  end

  // ---- stage 4: span and result word ----
  logic [CW-1:0]     s4_lo, s4_hi;
  logic [CW+OCW-1:0] x_ext, lo_ext, hi_ext;

  assign s4_lo  = (col_a < col_b) ? col_a : col_b;
  assign s4_hi  = (col_a < col_b) ? col_b : col_a;
  assign x_ext  = {{OCW{1'b0}}, s4_x_r};
  assign lo_ext = {{OCW{1'b0}}, s4_lo};
  assign hi_ext = {{OCW{1'b0}}, s4_hi};

  always_comb begin
    res = '0;
    unique case (s4_cmd_r.kind)
      asc_pkg::KIND_SAMPLE: begin
        res.word   = s4_cmd_r.scaled[asc_pkg::WORD_W-1:0];
        res.row_ok = 1'b1;
      end
      asc_pkg::KIND_CAPTURE: begin
        res.x_pos  = x_ext[OCW-1:0];
        res.row_ok = s4_cmd_r.row_ok;
      end
      asc_pkg::KIND_RENDER: begin
        if (s4_cmd_r.row_ok) begin
          res.span_lo = lo_ext[OCW-1:0];
          res.span_hi = hi_ext[OCW-1:0];
          res.row_ok  = 1'b1;
        end
      end
      asc_pkg::KIND_NONE: begin
        res = '0;
      end
    endcase
  end

  assign res_valid     = s4_vld_r;
  assign stat.clearing = clr_r;

endmodule

`default_nettype wire

/* design/audio_scope_trace_capture.sv */
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   in_req_type, in_sample_raw, in_row_index
// out_      output     out_valid / out_ready out_word, out_x_pos, out_span_lo,
//                                            out_span_hi, out_row_ok
//
// One word per cycle sustained while the output keeps up; steps to out_valid:
// command queue head + issue (counters, ring RAM port), reciprocal multiply,
// quotient correction, clamp + column RAM port, span/result build.
// After reset in_ready stays low while the column store is filled with the
// mid-screen column; the sample ring needs no pass, a fill count makes
// unwritten entries read as zero.
// A stalled output fills an 8-word result queue; issue holds off on credit,
// then the command queue fills and in_ready drops.

module audio_scope_trace_capture #(
  parameter int RING_DEPTH   = 1024,
  parameter int STEP_SIZE    = 2,
  parameter int SCREEN_WIDTH = 240,
  parameter int SCREEN_ROWS  = 320
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [23:0] in_sample_raw,
  input  wire logic [8:0]  in_row_index,

  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [23:0] out_word,
  output      logic [7:0]  out_x_pos,
  output      logic [7:0]  out_span_lo,
  output      logic [7:0]  out_span_hi,
  output      logic        out_row_ok
);

  // front end: decode request, pre-scale sample, range-check the row
  asc_pkg::stat_t stat;
  asc_pkg::cmd_t  fe_cmd;
  logic           fe_valid, fe_ready;

  asc_front #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (in_req_type),
    .sample_raw (in_sample_raw),
    .row_index  (in_row_index),
    .stat       (stat),
    .q_valid    (fe_valid),
    .q_ready    (fe_ready),
    .q_cmd      (fe_cmd)
  );

  // short command queue decouples decode from execution
  asc_pkg::cmd_t q_head;
  logic          q_valid, q_ready;

  asc_fifo #(
    .WIDTH ($bits(asc_pkg::cmd_t)),
    .DEPTH (asc_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  (fe_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_head),
    .count      ()
  );

  // back end: free-running pipeline, issue gated by result-queue credit
  asc_pkg::res_t                 be_res;
  logic                          be_valid;
  logic [asc_pkg::RES_CNT_W-1:0] res_count;

  asc_back #(
    .RING_DEPTH   (RING_DEPTH),
    .STEP_SIZE    (STEP_SIZE),
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_ROWS  (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_head),
    .res_count (res_count),
    .res_valid (be_valid),
    .res       (be_res),
    .stat      (stat)
  );

  // result queue; credit check guarantees it never overflows
  asc_pkg::res_t out_res;

  asc_fifo #(
    .WIDTH ($bits(asc_pkg::res_t)),
    .DEPTH (asc_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (be_valid),
    .push_ready (),
    .push_data  (be_res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_res),
    .count      (res_count)
  );

  assign out_word    = out_res.word;
  assign out_x_pos   = out_res.x_pos;
  assign out_span_lo = out_res.span_lo;
  assign out_span_hi = out_res.span_hi;
  assign out_row_ok  = out_res.row_ok;

endmodule

`default_nettype wire

/* dv/audio_scope_trace_capture_test.sv */
module audio_scope_trace_capture_test;

  // Block geometry, kept equal to the instance parameters below
  localparam int RING_N   = 1024;
  localparam int STEP_N   = 2;
  localparam int SCREEN_W = 240;
  localparam int SCREEN_H = 320;

  // req_type code that the block has no use for; it must answer with an all-zero word
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Run control. The cycle limit covers the worst case: every word waiting out a full
  // receiver stall plus a sender gap, plus the column clearing pass after reset.
  localparam int TOTAL_WORDS  = 1950;
  localparam int OVERRUN_AT   = 700;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 600000;

  // Mirror of the capture/render state. Every accepted input word pushes exactly one
  // expected result word; every accepted output word is compared against the oldest one.
  class scope_trace_checker;
    logic signed [asc_pkg::SAMPLE_W-1:0] sample_ring [RING_N];
    logic [asc_pkg::OUT_COL_W-1:0]       column_store [SCREEN_H];
    logic [31:0]                         write_count;
    logic [31:0]                         read_count;
    asc_pkg::res_t                       expected_words [$];
    int                                  errors;

    function new();
      foreach (sample_ring[i]) sample_ring[i] = '0;
      foreach (column_store[i]) column_store[i] = asc_pkg::OUT_COL_W'(SCREEN_W / 2);
      write_count = '0;
      read_count  = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Screen column for a scaled sample: mid column plus a quotient that truncates
    // toward zero, clamped onto the screen
    function logic [asc_pkg::OUT_COL_W-1:0] column_for(
        logic signed [asc_pkg::SAMPLE_W-1:0] v);
      longint signed s;
      longint signed col;
      s   = v;
      col = longint'(SCREEN_W / 2)
          + s / longint'(asc_pkg::FULL_SCALE / (SCREEN_W / 2));
      if (col < 0) col = 0;
      if (col >= SCREEN_W) col = SCREEN_W - 1;
      return asc_pkg::OUT_COL_W'(col);
    endfunction

    function void note_word(logic [1:0] req, logic [asc_pkg::RAW_W-1:0] raw,
                            logic [asc_pkg::ROW_W-1:0] row);
      asc_pkg::res_t                 r;
      logic [asc_pkg::SAMPLE_W-1:0]  scaled;
      logic [31:0]                   newest;
      logic [asc_pkg::OUT_COL_W-1:0] a;
      logic [asc_pkg::OUT_COL_W-1:0] b;
      r = '0;
      case (req)
        asc_pkg::REQ_SAMPLE: begin
          // sign extension then times four is a plain left shift at 26 bits
          scaled = {raw, 2'b00};
          sample_ring[write_count % 32'(RING_N)] = scaled;
          write_count = write_count + 32'd1;
          r.word   = scaled[asc_pkg::WORD_W-1:0];
          r.row_ok = 1'b1;
        end
        asc_pkg::REQ_CAPTURE: begin
          if (write_count - read_count >= 32'(STEP_N)) read_count = read_count + 32'(STEP_N);
          // overrun: jump to half a ring behind the writer
          if (write_count - read_count > 32'(RING_N))
            read_count = write_count - 32'(RING_N / 2);
          newest  = read_count - 32'd1;
          r.x_pos = column_for(sample_ring[newest % 32'(RING_N)]);
          if (32'(row) < 32'(SCREEN_H)) begin
            column_store[row] = r.x_pos;
            r.row_ok = 1'b1;
          end
        end
        asc_pkg::REQ_RENDER: begin
          if (32'(row) + 32'd1 < 32'(SCREEN_H)) begin
            a = column_store[row];
            b = column_store[row + 9'd1];
            r.span_lo = (a < b) ? a : b;
            r.span_hi = (a < b) ? b : a;
            r.row_ok  = 1'b1;
          end
        end
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [asc_pkg::WORD_W-1:0] word,
                             logic [asc_pkg::OUT_COL_W-1:0] x_pos,
                             logic [asc_pkg::OUT_COL_W-1:0] span_lo,
                             logic [asc_pkg::OUT_COL_W-1:0] span_hi,
                             logic row_ok);
      asc_pkg::res_t r;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, actual word %0d x_pos %0d", $time,
                 word, x_pos);
        return;
      end
      r = expected_words.pop_front();
      check_field("out_word", r.word, word);
      check_field("out_x_pos", r.x_pos, x_pos);
      check_field("out_span_lo", r.span_lo, span_lo);
      check_field("out_span_hi", r.span_hi, span_hi);
      check_field("out_row_ok", r.row_ok, row_ok);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [23:0] in_sample_raw;
  logic [8:0]  in_row_index;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_word;
  logic [7:0]  out_x_pos;
  logic [7:0]  out_span_lo;
  logic [7:0]  out_span_hi;
  logic        out_row_ok;

  scope_trace_checker trace_sb;

  int words_sent  = 0;
  int burst_left  = 0;
  int hold_cnt    = 0;
  int cycle_count = 0;
  logic ready_level = 1'b0;

  audio_scope_trace_capture #(
    .RING_DEPTH  (RING_N),
    .STEP_SIZE   (STEP_N),
    .SCREEN_WIDTH(SCREEN_W),
    .SCREEN_ROWS (SCREEN_H)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_sample_raw(in_sample_raw),
    .in_row_index (in_row_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .out_x_pos    (out_x_pos),
    .out_span_lo  (out_span_lo),
    .out_span_hi  (out_span_hi),
    .out_row_ok   (out_row_ok)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: a lost or stuck word ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitor. Both handshakes are sampled at the rising edge, before the block's own
  // registers update. The input word is noted first so an answer in the same cycle would still
  // find its expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) trace_sb.note_word(in_req_type, in_sample_raw, in_row_index);
      if (out_valid && out_ready)
        trace_sb.check_word(out_word, out_x_pos, out_span_lo, out_span_hi, out_row_ok);
    end
  end

  // Receiver back-pressure: alternating ready and stall stretches of random length.
  // Occasional long ready runs give stall-free stretches; occasional long stalls
  // fill the 8-deep result queue and push back onto in_ready.
  always @(negedge clk) begin
    if (hold_cnt == 0) begin
      ready_level = !ready_level;
      if (ready_level)
        hold_cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      else
        hold_cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
    end
    hold_cnt--;
    out_ready <= ready_level;
  end

  // Sends one word; entered and left at a falling edge. The sender works in bursts:
  // at the end of a burst it drops valid for a random gap. valid is only lowered by the
  // gap, so back-to-back words keep it high without a second assignment in one step.
  task automatic send_word(logic [1:0] req, logic [23:0] raw, logic [8:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_sample_raw <= raw;
    in_row_index  <= row;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Hold the input off until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (trace_sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Converter words: some full range (mostly clamped columns), most within the span
  // that maps onto the screen so the column actually moves
  function automatic logic [23:0] pick_raw();
    int v;
    if ($urandom_range(0, 9) < 4) return 24'($urandom());
    v = int'($urandom_range(0, 4400000)) - 2200000;
    return v[23:0];
  endfunction

  // Rows: mostly on screen, some at the bottom edge, a few past it
  function automatic logic [8:0] pick_row();
    case ($urandom_range(0, 19))
      0:       return 9'($urandom_range(320, 511));
      1, 2:    return 9'($urandom_range(310, 319));
      default: return 9'($urandom_range(0, 319));
    endcase
  endfunction

  initial begin
    int  sel;
    int  n;
    int  k;
    logic [8:0] base;
    bit  overrun_done;

    trace_sb      = new();
    overrun_done  = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = asc_pkg::REQ_SAMPLE;
    in_sample_raw = '0;
    in_row_index  = '0;
    out_ready     = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed words ----
    // capture on an empty ring: too few samples, reads the never-written last entry
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd0);
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd0);
    // full-scale extremes, then a capture that lands on the most negative one
    send_word(asc_pkg::REQ_SAMPLE,  24'h7FFFFF, 9'd0);
    send_word(asc_pkg::REQ_SAMPLE,  24'h800000, 9'd511);
    send_word(asc_pkg::REQ_CAPTURE, 24'hFFFFFF, 9'd5);
    // nothing new waiting: read count stays, last sample reused
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd6);
    send_word(asc_pkg::REQ_SAMPLE,  24'hFFFFFF, 9'd0);
    send_word(asc_pkg::REQ_SAMPLE,  24'h000000, 9'd0);
    // just under the right clamp, and just inside the left one
    send_word(asc_pkg::REQ_SAMPLE,  24'h1FFFFF, 9'd0);
    send_word(asc_pkg::REQ_SAMPLE,  24'hE00001, 9'd0);
    // last on-screen row, then rows past the bottom: column computed, nothing stored
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd319);
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd320);
    send_word(asc_pkg::REQ_SAMPLE,  24'h555555, 9'h0AA);
    send_word(asc_pkg::REQ_SAMPLE,  24'hAAAAAA, 9'h155);
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd511);
    send_word(asc_pkg::REQ_CAPTURE, 24'h000000, 9'd318);
    // spans: normal, second to last, last row and beyond have no successor
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd5);
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd318);
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd319);
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd320);
    send_word(asc_pkg::REQ_RENDER,  24'hFFFFFF, 9'd511);
    // unused request code: no state change, zero word back
    send_word(REQ_UNUSED,           24'hFFFFFF, 9'd511);
    send_word(REQ_UNUSED,           24'h000000, 9'd0);
    send_word(asc_pkg::REQ_RENDER,  24'h000000, 9'd4);

    wait_drained();

    // ---- random traffic ----
    while (words_sent < TOTAL_WORDS) begin
      if (!overrun_done && words_sent >= OVERRUN_AT) begin
        // writer runs more than a full ring ahead; the next capture must resync
        wait_drained();
        repeat ($urandom_range(1030, 1060))
          send_word(asc_pkg::REQ_SAMPLE, pick_raw(), 9'($urandom()));
        base = 9'($urandom_range(0, 300));
        for (k = 0; k < 3; k++)
          send_word(asc_pkg::REQ_CAPTURE, 24'($urandom()), base + 9'(k));
        for (k = 0; k < 3; k++)
          send_word(asc_pkg::REQ_RENDER, 24'($urandom()), base + 9'(k));
        overrun_done = 1'b1;
      end
      if ($urandom_range(0, 59) == 0) wait_drained();

      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        // typical frame slice: samples, captures on neighboring rows, then their spans
        n = $urandom_range(1, 10);
        repeat (n) send_word(asc_pkg::REQ_SAMPLE, pick_raw(), 9'($urandom()));
        base = pick_row();
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_word(asc_pkg::REQ_CAPTURE, 24'($urandom()), base + 9'(k));
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
          send_word(asc_pkg::REQ_RENDER, 24'($urandom()), base - 9'd1 + 9'(k));
      end else if (sel < 82) begin
        // noise: any code, any fields
        send_word(2'($urandom()), 24'($urandom()), 9'($urandom()));
      end else if (sel < 92) begin
        // captures outrunning the samples
        base = pick_row();
        n = $urandom_range(2, 5);
        for (k = 0; k < n; k++)
          send_word(asc_pkg::REQ_CAPTURE, 24'($urandom()), base + 9'(k));
      end else begin
        base = pick_row();
        n = $urandom_range(3, 8);
        for (k = 0; k < n; k++)
          send_word(asc_pkg::REQ_RENDER, 24'($urandom()), base + 9'(k));
      end
    end

    // ---- wrap up: drain, then watch a little longer for stray words ----
    in_valid <= 1'b0;
    while (trace_sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (trace_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
